// ===== hdl/phdt_pkg.sv =====
// Shared types and constants for the pressure history and drift tracker.
`timescale 1ns / 1ps

package phdt_pkg;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  localparam logic [1:0] REG_INTERVAL     = 2'd0;
  localparam logic [1:0] REG_SHORT_WINDOW = 2'd1;
  localparam logic [1:0] REG_LONG_WINDOW  = 2'd2;

  localparam logic [31:0] INTERVAL_RESET     = 32'd300000;
  localparam logic [31:0] SHORT_WINDOW_RESET = 32'd3600000;
  localparam logic [31:0] LONG_WINDOW_RESET  = 32'd86400000;

  typedef struct packed {
    logic [31:0]        ts;
    logic signed [15:0] pres;
    logic [7:0]         st;
    logic               ok;
  } hist_entry_t;

  typedef struct packed {
    logic [31:0]        ts;
    logic signed [15:0] pres;
    logic               ok;
  } snap_entry_t;

  typedef struct packed {
    logic       wr;
    logic       rd;
    logic [7:0] index;
  } hist_req_t;

endpackage

// ===== hdl/phdt_history.sv =====
// History ring: entry memory with head, tail and fill count, append and indexed read.
`timescale 1ns / 1ps

module phdt_history import phdt_pkg::*; #(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  hist_req_t   req,
  input  hist_entry_t wdata,
  output logic        present,
  output hist_entry_t rdata
);

  localparam int HPW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HCW = $clog2(HISTORY_DEPTH + 1);
  localparam int IW  = ((HPW > 8) ? HPW : 8) + 1;
  localparam int XW  = (HCW > IW) ? HCW : IW;

  hist_entry_t mem [HISTORY_DEPTH];

  logic [HPW-1:0] head;
  logic [HPW-1:0] tail;
  logic [HCW-1:0] count;

  logic [XW-1:0]  sum;
  logic [XW-1:0]  wrapped;
  logic [HPW-1:0] rd_addr;
  logic           present_c;
  logic           full;

  function automatic logic [HPW-1:0] inc_ptr(input logic [HPW-1:0] p);
    return (p == HPW'(HISTORY_DEPTH - 1)) ? '0 : p + HPW'(1);
  endfunction

  always_comb begin
    sum       = XW'(head) + XW'(req.index);
    wrapped   = (sum >= XW'(HISTORY_DEPTH)) ? sum - XW'(HISTORY_DEPTH) : sum;
    rd_addr   = wrapped[HPW-1:0];
    present_c = XW'(req.index) < XW'(count);
    full      = (count == HCW'(HISTORY_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      count   <= '0;
      present <= 1'b0;
    end else begin
      if (req.wr) begin
        tail <= inc_ptr(tail);
        if (full) begin
          head <= inc_ptr(head);
        end else begin
          count <= count + HCW'(1);
        end
      end
      if (req.rd) begin
        present <= present_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[tail] <= wdata;
    end
    if (req.rd) begin
      rdata <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/pressure_history_drift_tracker_top.sv =====
// Top level of the pressure history and drift tracker: command sequencer and snapshot ring.
//
// Channel   Signals                                         Handshake
// command   start, busy, command .. entry_index             taken when start high, busy low
// result    done, drift_short .. entry_valid                one cycle on done, no back-pressure
// config    cfg_write, cfg_index, cfg_data                  written when cfg_write high
//
// An add passes through S_ADD, and a history read through S_HREAD and S_HOUT, before done.
// A query walks the snapshot memory backwards twice, one entry per cycle through its
// single read port, first for the short window and then for the long window.
// Reset is synchronous; the block takes an item on the first cycle after reset.
// The next item may be accepted in the cycle in which done is high.
`timescale 1ns / 1ps

module pressure_history_drift_tracker_top import phdt_pkg::*; #(
  parameter int HISTORY_DEPTH  = 256,
  parameter int SNAPSHOT_DEPTH = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic [31:0]        timestamp_ms,
  input  logic signed [15:0] pressure_value,
  input  logic               reading_valid,
  input  logic [7:0]         state_code,
  input  logic [7:0]         entry_index,
  output logic               done,
  output logic signed [16:0] drift_short,
  output logic               drift_short_valid,
  output logic signed [16:0] drift_long,
  output logic               drift_long_valid,
  output logic               entry_present,
  output logic [31:0]        entry_timestamp,
  output logic signed [15:0] entry_pressure,
  output logic [7:0]         entry_state,
  output logic               entry_valid,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int SPW = $clog2(SNAPSHOT_DEPTH);
  localparam int SCW = $clog2(SNAPSHOT_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ADD   = 5'b00010,
    S_HREAD = 5'b00100,
    S_HOUT  = 5'b01000,
    S_SCAN  = 5'b10000
  } state_t;

  state_t state;

  logic [31:0] snapshot_interval;
  logic [31:0] short_window;
  logic [31:0] long_window;

  logic [31:0]        ts_q;
  logic signed [15:0] pres_q;
  logic               ok_q;
  logic [7:0]         st_q;
  logic [7:0]         idx_q;

  snap_entry_t    snap_mem [SNAPSHOT_DEPTH];
  snap_entry_t    snap_rdata;
  logic [SPW-1:0] snap_head;
  logic [SPW-1:0] snap_tail;
  logic [SCW-1:0] snap_count;
  logic [31:0]    last_snapshot_time;

  logic [31:0]    target;
  logic [SPW-1:0] scan_ptr;
  logic [SCW-1:0] scan_left;
  logic           rd_pend;
  logic           long_pass;

  logic           take;
  logic           snap_we;
  logic           snap_rd_en;
  logic           snap_full;
  logic [SPW-1:0] newest_ptr;
  logic           hit;
  logic signed [16:0] diff;
  snap_entry_t    snap_wdata;

  hist_req_t   hist_req;
  hist_entry_t hist_wdata;
  hist_entry_t hist_rdata;
  logic        hist_present;

  function automatic logic [SPW-1:0] inc_snap(input logic [SPW-1:0] p);
    return (p == SPW'(SNAPSHOT_DEPTH - 1)) ? '0 : p + SPW'(1);
  endfunction

  function automatic logic [SPW-1:0] dec_snap(input logic [SPW-1:0] p);
    return (p == '0) ? SPW'(SNAPSHOT_DEPTH - 1) : p - SPW'(1);
  endfunction

  always_comb begin
    busy       = (state != S_IDLE);
    take       = (last_snapshot_time == 32'd0) ||
                 ((ts_q - last_snapshot_time) >= snapshot_interval);
    snap_we    = (state == S_ADD) && take;
    snap_full  = (snap_count == SCW'(SNAPSHOT_DEPTH));
    snap_rd_en = (state == S_SCAN) && (scan_left != '0);
    newest_ptr = dec_snap(snap_tail);
    hit        = rd_pend && (snap_rdata.ts <= target);
    diff       = {pres_q[15], pres_q} - {snap_rdata.pres[15], snap_rdata.pres};

    snap_wdata.ts   = ts_q;
    snap_wdata.pres = pres_q;
    snap_wdata.ok   = ok_q;

    hist_wdata.ts   = ts_q;
    hist_wdata.pres = pres_q;
    hist_wdata.st   = st_q;
    hist_wdata.ok   = ok_q;

    hist_req.wr    = (state == S_ADD);
    hist_req.rd    = (state == S_HREAD);
    hist_req.index = idx_q;
  end

  phdt_history #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk    (clk),
    .rst    (rst),
    .req    (hist_req),
    .wdata  (hist_wdata),
    .present(hist_present),
    .rdata  (hist_rdata)
  );

  always_ff @(posedge clk) begin
    if (snap_we) begin
      snap_mem[snap_tail] <= snap_wdata;
    end
    if (snap_rd_en) begin
      snap_rdata <= snap_mem[scan_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      done               <= 1'b0;
      snapshot_interval  <= INTERVAL_RESET;
      short_window       <= SHORT_WINDOW_RESET;
      long_window        <= LONG_WINDOW_RESET;
      snap_head          <= '0;
      snap_tail          <= '0;
      snap_count         <= '0;
      last_snapshot_time <= '0;
      scan_left          <= '0;
      rd_pend            <= 1'b0;
      long_pass          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_INTERVAL:     snapshot_interval <= cfg_data;
          REG_SHORT_WINDOW: short_window      <= cfg_data;
          REG_LONG_WINDOW:  long_window       <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            ts_q              <= timestamp_ms;
            pres_q            <= pressure_value;
            ok_q              <= reading_valid;
            st_q              <= state_code;
            idx_q             <= entry_index;
            drift_short       <= '0;
            drift_short_valid <= 1'b0;
            drift_long        <= '0;
            drift_long_valid  <= 1'b0;
            entry_present     <= 1'b0;
            entry_timestamp   <= '0;
            entry_pressure    <= '0;
            entry_state       <= '0;
            entry_valid       <= 1'b0;
            unique case (command)
              CMD_ADD: begin
                state <= S_ADD;
              end
              CMD_QUERY: begin
                target    <= timestamp_ms - short_window;
                scan_left <= snap_count;
                scan_ptr  <= newest_ptr;
                rd_pend   <= 1'b0;
                long_pass <= 1'b0;
                state     <= S_SCAN;
              end
              CMD_READ: begin
                state <= S_HREAD;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_ADD: begin
          if (take) begin
            last_snapshot_time <= ts_q;
            snap_tail          <= inc_snap(snap_tail);
            if (snap_full) begin
              snap_head <= inc_snap(snap_head);
            end else begin
              snap_count <= snap_count + SCW'(1);
            end
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_HREAD: begin
          state <= S_HOUT;
        end
        S_HOUT: begin
          if (hist_present) begin
            entry_present   <= 1'b1;
            entry_timestamp <= hist_rdata.ts;
            entry_pressure  <= hist_rdata.pres;
            entry_state     <= hist_rdata.st;
            entry_valid     <= hist_rdata.ok;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (hit || (!rd_pend && scan_left == '0)) begin
            if (hit && snap_rdata.ok && ok_q) begin
              if (long_pass) begin
                drift_long       <= diff;
                drift_long_valid <= 1'b1;
              end else begin
                drift_short       <= diff;
                drift_short_valid <= 1'b1;
              end
            end
            if (long_pass) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              long_pass <= 1'b1;
              target    <= ts_q - long_window;
              scan_left <= snap_count;
              scan_ptr  <= newest_ptr;
              rd_pend   <= 1'b0;
            end
          end else begin
            rd_pend <= (scan_left != '0);
            if (scan_left != '0) begin
              scan_ptr  <= dec_snap(scan_ptr);
              scan_left <= scan_left - SCW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
